// ===== hdl/fpfa_pkg.sv =====
// Shared codes and constants of the fixed partition fit allocator.
package fpfa_pkg;

  localparam int unsigned AMOUNT_BITS = 16;
  localparam int unsigned SEL_BITS    = 4;
  localparam int unsigned PID_BITS    = 8;
  localparam int unsigned INDEX_BITS  = 4;
  localparam int unsigned COUNT_BITS  = 5;

  localparam logic [1:0] STATUS_PLACED = 2'd0;
  localparam logic [1:0] STATUS_NOFIT  = 2'd1;
  localparam logic [1:0] STATUS_LOADED = 2'd2;

  localparam logic [1:0] MODE_FIRST = 2'd0;
  localparam logic [1:0] MODE_BEST  = 2'd1;
  localparam logic [1:0] MODE_NEXT  = 2'd2;
  localparam logic [1:0] MODE_WORST = 2'd3;

  localparam logic CFG_FIT_MODE   = 1'b0;
  localparam logic CFG_PART_COUNT = 1'b1;

  localparam logic [COUNT_BITS-1:0] COUNT_RESET = 5'd16;

endpackage

// ===== hdl/fpfa_table.sv =====
// Partition table: size memory with loaded marks, busy marks and owner memory.
module fpfa_table import fpfa_pkg::*; #(
  parameter int unsigned PARTITIONS = 16,
  parameter int unsigned SIZE_BITS  = 16,
  parameter int unsigned IW         = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_en_i,
  input  logic [IW-1:0]        load_idx_i,
  input  logic [SIZE_BITS-1:0] load_size_i,
  input  logic                 place_en_i,
  input  logic [IW-1:0]        place_idx_i,
  input  logic [PID_BITS-1:0]  place_owner_i,
  input  logic                 rd_en_i,
  input  logic [IW-1:0]        rd_addr_i,
  output logic [SIZE_BITS-1:0] rd_size_o,
  output logic                 rd_busy_o
);

  logic [SIZE_BITS-1:0] size_mem [PARTITIONS];
  logic [PID_BITS-1:0]  owner_mem [PARTITIONS];
  logic [PARTITIONS-1:0] loaded_q;
  logic [PARTITIONS-1:0] busy_q;
  logic [SIZE_BITS-1:0] size_rd_q;
  logic                 loaded_rd_q;
  logic                 busy_rd_q;

  always_ff @(posedge clk_i) begin
    if (load_en_i) begin
      size_mem[load_idx_i] <= load_size_i;
    end
    if (rd_en_i) begin
      size_rd_q <= size_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (place_en_i) begin
      owner_mem[place_idx_i] <= place_owner_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q    <= '0;
      busy_q      <= '0;
      loaded_rd_q <= 1'b0;
      busy_rd_q   <= 1'b0;
    end else begin
      if (load_en_i) begin
        loaded_q[load_idx_i] <= 1'b1;
        busy_q[load_idx_i]   <= 1'b0;
      end
      if (place_en_i) begin
        busy_q[place_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        loaded_rd_q <= loaded_q[rd_addr_i];
        busy_rd_q   <= busy_q[rd_addr_i];
      end
    end
  end

  assign rd_size_o = loaded_rd_q ? size_rd_q : '0;
  assign rd_busy_o = busy_rd_q;

endmodule

// ===== hdl/fpfa_fit_unit.sv =====
// Shared compare and subtract unit that judges one partition against the request.
module fpfa_fit_unit import fpfa_pkg::*; #(
  parameter int unsigned SIZE_BITS = 16,
  parameter int unsigned CW        = 16
) (
  input  logic [1:0]             mode_i,
  input  logic [SIZE_BITS-1:0]   size_i,
  input  logic                   busy_i,
  input  logic [AMOUNT_BITS-1:0] need_i,
  input  logic                   have_pick_i,
  input  logic [CW-1:0]          pick_left_i,
  output logic [CW-1:0]          left_o,
  output logic                   take_o
);

  logic [CW-1:0] size_ext;
  logic [CW-1:0] need_ext;
  logic          fits;

  assign size_ext = CW'(size_i);
  assign need_ext = CW'(need_i);
  assign fits     = !busy_i && (size_ext >= need_ext);
  assign left_o   = size_ext - need_ext;

  always_comb begin
    take_o = 1'b0;
    if (fits) begin
      if (!have_pick_i) begin
        take_o = 1'b1;
      end else begin
        case (mode_i)
          MODE_BEST:  take_o = left_o < pick_left_i;
          MODE_WORST: take_o = left_o > pick_left_i;
          default:    take_o = 1'b0;
        endcase
      end
    end
  end

endmodule

// ===== hdl/fixed_partition_fit_allocator.sv =====
// Top level of the fixed partition fit allocator: sequencer, scan pipeline and output word.
//
// Input words arrive on in_valid_i/in_stall_o and result words leave on
// out_valid_o/out_stall_i; a word moves when valid is high and stall is low.
// A load word writes one partition size and frees that partition; its result
// word is registered from the finish state, and then the next input word is
// accepted. An allocate word scans the N partitions in use, one table read per
// cycle through a single compare and subtract unit, passes the drain state and
// registers its result from the finish state; with no partition in use it goes
// straight to finish like a load. The block takes no new input word while a
// word is in progress. A finished result sits in an output register; the next
// word may be accepted while it waits, and the sequencer holds its following
// result until the receiver takes the previous one. Configuration is written
// through cfg_we_i, cfg_index_i and cfg_data_i; the user must do so only while
// the block is idle, as the block does not enforce it. Reset selects first fit,
// sixteen partitions in use, all sizes zero and all partitions free.
module fixed_partition_fit_allocator import fpfa_pkg::*; #(
  parameter int unsigned PARTITIONS = 16,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_index_i,
  input  logic [COUNT_BITS-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   in_action_i,
  input  logic [SEL_BITS-1:0]    in_partition_sel_i,
  input  logic [AMOUNT_BITS-1:0] in_amount_i,
  input  logic [PID_BITS-1:0]    in_process_id_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             out_status_o,
  output logic [INDEX_BITS-1:0]  out_placed_index_o,
  output logic [AMOUNT_BITS-1:0] out_fragmentation_o
);

  localparam int unsigned IW   = $clog2(PARTITIONS);
  localparam int unsigned CNTW = $clog2(PARTITIONS + 1);
  localparam int unsigned MW   = (CNTW > COUNT_BITS) ? CNTW : COUNT_BITS;
  localparam int unsigned SW   = (IW > SEL_BITS) ? IW : SEL_BITS;
  localparam int unsigned CW   = (SIZE_BITS > AMOUNT_BITS) ? SIZE_BITS : AMOUNT_BITS;
  localparam logic [MW-1:0] PART_LIM = MW'(PARTITIONS);
  localparam logic [SW:0]   SEL_LIM  = (SW + 1)'(PARTITIONS);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [1:0]             mode_q;
  logic [COUNT_BITS-1:0]  count_q;
  logic [IW-1:0]          last_q, last_d;
  logic                   is_load_q, is_load_d;
  logic [AMOUNT_BITS-1:0] need_q, need_d;
  logic [PID_BITS-1:0]    pid_q, pid_d;
  logic [IW-1:0]          k_q, k_d;
  logic [CNTW-1:0]        remain_q, remain_d;
  logic                   ev_vld_q, ev_vld_d;
  logic [IW-1:0]          ev_idx_q, ev_idx_d;
  logic                   have_q, have_d;
  logic [IW-1:0]          pick_q, pick_d;
  logic [CW-1:0]          pick_left_q, pick_left_d;
  logic                   out_valid_q, out_valid_d;
  logic [1:0]             status_q, status_d;
  logic [INDEX_BITS-1:0]  index_q, index_d;
  logic [AMOUNT_BITS-1:0] frag_q, frag_d;

  logic [MW-1:0]          count_ext;
  logic [MW-1:0]          eff_wide;
  logic [CNTW-1:0]        eff;
  logic [IW-1:0]          start;
  logic [SW-1:0]          sel_ext;
  logic                   accept;
  logic                   slot_free;
  logic                   load_en;
  logic                   place_en;
  logic                   rd_en;
  logic [SIZE_BITS-1:0]   rd_size;
  logic                   rd_busy;
  logic [CW-1:0]          left;
  logic                   take;
  logic [IW+INDEX_BITS-1:0] pick_pad;

  assign count_ext = MW'(count_q);
  assign eff_wide  = (count_ext > PART_LIM) ? PART_LIM : count_ext;
  assign eff       = eff_wide[CNTW-1:0];
  assign start     = ((mode_q == MODE_NEXT) && (CNTW'(last_q) < eff)) ? last_q : '0;
  assign sel_ext   = SW'(in_partition_sel_i);
  assign pick_pad  = {{INDEX_BITS{1'b0}}, pick_q};

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign load_en    = accept && !in_action_i && ({1'b0, sel_ext} < SEL_LIM);
  assign rd_en      = (state_q == ST_SCAN);
  assign place_en   = (state_q == ST_FINISH) && slot_free && !is_load_q && have_q;

  fpfa_table #(
    .PARTITIONS (PARTITIONS),
    .SIZE_BITS  (SIZE_BITS),
    .IW         (IW)
  ) u_table (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_en_i     (load_en),
    .load_idx_i    (sel_ext[IW-1:0]),
    .load_size_i   (SIZE_BITS'(in_amount_i)),
    .place_en_i    (place_en),
    .place_idx_i   (pick_q),
    .place_owner_i (pid_q),
    .rd_en_i       (rd_en),
    .rd_addr_i     (k_q),
    .rd_size_o     (rd_size),
    .rd_busy_o     (rd_busy)
  );

  fpfa_fit_unit #(
    .SIZE_BITS (SIZE_BITS),
    .CW        (CW)
  ) u_fit (
    .mode_i      (mode_q),
    .size_i      (rd_size),
    .busy_i      (rd_busy),
    .need_i      (need_q),
    .have_pick_i (have_q),
    .pick_left_i (pick_left_q),
    .left_o      (left),
    .take_o      (take)
  );

  always_comb begin
    state_d     = state_q;
    last_d      = last_q;
    is_load_d   = is_load_q;
    need_d      = need_q;
    pid_d       = pid_q;
    k_d         = k_q;
    remain_d    = remain_q;
    ev_vld_d    = 1'b0;
    ev_idx_d    = k_q;
    have_d      = have_q;
    pick_d      = pick_q;
    pick_left_d = pick_left_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    index_d     = index_q;
    frag_d      = frag_q;

    if (ev_vld_q && take) begin
      have_d      = 1'b1;
      pick_d      = ev_idx_q;
      pick_left_d = left;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          is_load_d = !in_action_i;
          need_d    = in_amount_i;
          pid_d     = in_process_id_i;
          have_d    = 1'b0;
          k_d       = start;
          remain_d  = eff;
          if (in_action_i && (eff != '0)) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        ev_vld_d = 1'b1;
        ev_idx_d = k_q;
        k_d      = ((CNTW'(k_q) + CNTW'(1)) == eff) ? '0 : k_q + IW'(1);
        remain_d = remain_q - CNTW'(1);
        if (remain_q == CNTW'(1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          index_d     = '0;
          frag_d      = '0;
          if (is_load_q) begin
            status_d = STATUS_LOADED;
          end else if (have_q) begin
            status_d = STATUS_PLACED;
            index_d  = pick_pad[INDEX_BITS-1:0];
            frag_d   = pick_left_q[AMOUNT_BITS-1:0];
            last_d   = pick_q;
          end else begin
            status_d = STATUS_NOFIT;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_FIRST;
      count_q     <= COUNT_RESET;
      last_q      <= '0;
      ev_vld_q    <= 1'b0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      ev_vld_q    <= ev_vld_d;
      have_q      <= have_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_FIT_MODE:   mode_q  <= cfg_data_i[1:0];
          CFG_PART_COUNT: count_q <= cfg_data_i;
          default:        count_q <= count_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    is_load_q   <= is_load_d;
    need_q      <= need_d;
    pid_q       <= pid_d;
    k_q         <= k_d;
    remain_q    <= remain_d;
    ev_idx_q    <= ev_idx_d;
    pick_q      <= pick_d;
    pick_left_q <= pick_left_d;
    status_q    <= status_d;
    index_q     <= index_d;
    frag_q      <= frag_d;
  end

  assign out_valid_o         = out_valid_q;
  assign out_status_o        = status_q;
  assign out_placed_index_o  = index_q;
  assign out_fragmentation_o = frag_q;

endmodule

// ===== bench/fixed_partition_fit_allocator_tb.sv =====
// Self-checking testbench of the fixed partition fit allocator: directed table, random phases.
module fixed_partition_fit_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fpfa_pkg::*;

  localparam int PARTS         = 16;
  localparam int PHASES        = 14;
  localparam int PHASE_WORDS   = 110;
  localparam int HANG_LIMIT    = 2000;
  localparam int TAIL_CYCLES   = 40;
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_ALLOC   = 1'b1;

  typedef struct packed {
    logic                   action;
    logic [SEL_BITS-1:0]    sel;
    logic [AMOUNT_BITS-1:0] amount;
    logic [PID_BITS-1:0]    pid;
  } word_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [INDEX_BITS-1:0]  index;
    logic [AMOUNT_BITS-1:0] frag;
  } outcome_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    word_t                 w;
    logic                  typed;
    outcome_t              res;
    logic                  cfg_idx;
    logic [COUNT_BITS-1:0] cfg_data;
  } row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic                   cfg_index_i = 1'b0;
  logic [COUNT_BITS-1:0]  cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic                   in_action_i = 1'b0;
  logic [SEL_BITS-1:0]    in_partition_sel_i = '0;
  logic [AMOUNT_BITS-1:0] in_amount_i = '0;
  logic [PID_BITS-1:0]    in_process_id_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [1:0]             out_status_o;
  logic [INDEX_BITS-1:0]  out_placed_index_o;
  logic [AMOUNT_BITS-1:0] out_fragmentation_o;

  logic [AMOUNT_BITS-1:0] part_len [PARTS];
  bit                     part_taken [PARTS];
  logic [INDEX_BITS-1:0]  last_pick = '0;
  logic [1:0]             cfg_mode = MODE_FIRST;
  logic [COUNT_BITS-1:0]  cfg_count = COUNT_RESET;

  outcome_t predicted_outcomes [$];
  row_t     plan [$];
  int       mismatches = 0;
  int       hang_cycles = 0;
  int       stall_left = 0;
  bit       quiet = 1'b0;

  fixed_partition_fit_allocator dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_action_i        (in_action_i),
    .in_partition_sel_i (in_partition_sel_i),
    .in_amount_i        (in_amount_i),
    .in_process_id_i    (in_process_id_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_status_o       (out_status_o),
    .out_placed_index_o (out_placed_index_o),
    .out_fragmentation_o(out_fragmentation_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic outcome_t predict_outcome(input word_t w);
    outcome_t              o;
    int                    span;
    int                    start_at;
    int                    i;
    int                    k;
    bit                    found;
    logic [AMOUNT_BITS-1:0] left;
    logic [AMOUNT_BITS-1:0] pick_left;
    logic [INDEX_BITS-1:0]  pick;
    o = '{STATUS_LOADED, '0, '0};
    if (w.action == ACT_LOAD) begin
      part_len[w.sel] = w.amount;
      part_taken[w.sel] = 1'b0;
      return o;
    end
    span = (cfg_count > COUNT_BITS'(PARTS)) ? PARTS : int'(cfg_count);
    start_at = (cfg_mode == MODE_NEXT && int'(last_pick) < span) ? int'(last_pick) : 0;
    found = 1'b0;
    pick = '0;
    pick_left = '0;
    for (i = 0; i < span; i++) begin
      k = (cfg_mode == MODE_NEXT) ? (start_at + i) % span : i;
      if (!part_taken[k] && part_len[k] >= w.amount) begin
        left = part_len[k] - w.amount;
        if (!found || (cfg_mode == MODE_BEST && left < pick_left) ||
            (cfg_mode == MODE_WORST && left > pick_left)) begin
          found = 1'b1;
          pick = k[INDEX_BITS-1:0];
          pick_left = left;
        end
      end
    end
    if (!found) begin
      o = '{STATUS_NOFIT, '0, '0};
    end else begin
      part_taken[pick] = 1'b1;
      last_pick = pick;
      o = '{STATUS_PLACED, pick, pick_left};
    end
    return o;
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [AMOUNT_BITS-1:0] pick_amount();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return AMOUNT_BITS'(16 << $urandom_range(0, 3));
    if (r < 70) return AMOUNT_BITS'($urandom_range(0, 255));
    if (r < 90) return AMOUNT_BITS'($urandom_range(0, 4095));
    return AMOUNT_BITS'($urandom_range(0, 65535));
  endfunction

  function automatic row_t word_row(input logic act, input logic [SEL_BITS-1:0] sel,
                                    input logic [AMOUNT_BITS-1:0] amount,
                                    input logic [PID_BITS-1:0] pid);
    row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.w = '{act, sel, amount, pid};
    return r;
  endfunction

  function automatic row_t cfg_row(input logic idx, input logic [COUNT_BITS-1:0] data);
    row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.cfg_idx = idx;
    r.cfg_data = data;
    return r;
  endfunction

  function automatic row_t checked(input row_t r, input logic [1:0] status,
                                   input logic [INDEX_BITS-1:0] index,
                                   input logic [AMOUNT_BITS-1:0] frag);
    row_t c;
    c = r;
    c.typed = 1'b1;
    c.res = '{status, index, frag};
    return c;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  task automatic send_word(input word_t w, input bit typed, input outcome_t res);
    outcome_t o;
    int       gap;
    in_valid_i <= 1'b1;
    in_action_i <= w.action;
    in_partition_sel_i <= w.sel;
    in_amount_i <= w.amount;
    in_process_id_i <= w.pid;
    do @(posedge clk_i); while (in_stall_o);
    o = predict_outcome(w);
    predicted_outcomes.push_back(typed ? res : o);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input logic idx, input logic [COUNT_BITS-1:0] data);
    in_valid_i <= 1'b0;
    while (predicted_outcomes.size() != 0) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_FIT_MODE) cfg_mode = data[1:0];
    else cfg_count = data;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    outcome_t want;
    if (out_valid_o && !out_stall_i) begin
      if (predicted_outcomes.size() == 0) begin
        report_mismatch($sformatf("result word with nothing pending, status %0d", out_status_o));
      end else begin
        want = predicted_outcomes.pop_front();
        if (out_status_o !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_status_o, want.status));
        if (out_placed_index_o !== want.index)
          report_mismatch($sformatf("placed_index %0d, expected %0d",
                                    out_placed_index_o, want.index));
        if (out_fragmentation_o !== want.frag)
          report_mismatch($sformatf("fragmentation %0d, expected %0d",
                                    out_fragmentation_o, want.frag));
      end
    end
    if (stall_left == 0) stall_left = pick_gap();
    out_stall_i <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) hang_cycles = 0;
    else hang_cycles++;
    if (hang_cycles >= HANG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    word_t w;
    int    span;
    int    p;
    int    n;
    foreach (part_len[i]) begin
      part_len[i] = '0;
      part_taken[i] = 1'b0;
    end
    plan = '{
      checked(word_row(ACT_ALLOC, 4'd0, 16'd0, 8'h00), STATUS_PLACED, 4'd0, 16'd0),
      checked(word_row(ACT_ALLOC, 4'd0, 16'd1, 8'hFF), STATUS_NOFIT, 4'd0, 16'd0),
      checked(word_row(ACT_LOAD, 4'd15, 16'hFFFF, 8'h00), STATUS_LOADED, 4'd0, 16'd0),
      word_row(ACT_ALLOC, 4'd0, 16'd0, 8'hAA),
      checked(word_row(ACT_ALLOC, 4'd0, 16'd1, 8'h55), STATUS_PLACED, 4'd15, 16'hFFFE),
      checked(word_row(ACT_LOAD, 4'd0, 16'hFFFF, 8'hFF), STATUS_LOADED, 4'd0, 16'd0),
      checked(word_row(ACT_ALLOC, 4'd0, 16'hFFFF, 8'h0F), STATUS_PLACED, 4'd0, 16'd0),
      word_row(ACT_LOAD, 4'd3, 16'd100, 8'h00),
      word_row(ACT_LOAD, 4'd5, 16'd40, 8'h00),
      word_row(ACT_LOAD, 4'd7, 16'd300, 8'h00),
      word_row(ACT_LOAD, 4'd9, 16'd40, 8'h00),
      cfg_row(CFG_FIT_MODE, COUNT_BITS'(MODE_BEST)),
      word_row(ACT_ALLOC, 4'd0, 16'd30, 8'h11),
      cfg_row(CFG_FIT_MODE, COUNT_BITS'(MODE_WORST)),
      word_row(ACT_ALLOC, 4'd0, 16'd30, 8'h22),
      cfg_row(CFG_FIT_MODE, COUNT_BITS'(MODE_NEXT)),
      word_row(ACT_ALLOC, 4'd0, 16'd30, 8'h33),
      word_row(ACT_ALLOC, 4'd0, 16'd30, 8'h44),
      cfg_row(CFG_PART_COUNT, 5'd0),
      checked(word_row(ACT_ALLOC, 4'd0, 16'd0, 8'h66), STATUS_NOFIT, 4'd0, 16'd0),
      cfg_row(CFG_PART_COUNT, 5'd31),
      word_row(ACT_ALLOC, 4'd0, 16'd0, 8'h77),
      cfg_row(CFG_PART_COUNT, 5'd2),
      checked(word_row(ACT_LOAD, 4'd1, 16'd5, 8'h88), STATUS_LOADED, 4'd0, 16'd0),
      word_row(ACT_ALLOC, 4'd0, 16'd0, 8'h99),
      cfg_row(CFG_PART_COUNT, 5'd1),
      word_row(ACT_ALLOC, 4'd0, 16'd0, 8'hCC)
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CFG) write_reg(plan[r].cfg_idx, plan[r].cfg_data);
      else send_word(plan[r].w, plan[r].typed, plan[r].res);
    end

    for (p = 0; p < PHASES; p++) begin
      write_reg(CFG_FIT_MODE, COUNT_BITS'(p % 4));
      case (p % 7)
        0, 5:    write_reg(CFG_PART_COUNT, 5'd16);
        1:       write_reg(CFG_PART_COUNT, 5'd1);
        2:       write_reg(CFG_PART_COUNT, 5'd31);
        3:       write_reg(CFG_PART_COUNT, 5'd0);
        4:       write_reg(CFG_PART_COUNT, COUNT_BITS'($urandom_range(2, 15)));
        default: write_reg(CFG_PART_COUNT, COUNT_BITS'($urandom_range(1, 16)));
      endcase
      quiet = (p % 5 == 2);
      span = (cfg_count > COUNT_BITS'(PARTS)) ? PARTS : int'(cfg_count);
      for (n = 0; n < PHASE_WORDS; n++) begin
        w.amount = pick_amount();
        w.pid = PID_BITS'($urandom_range(0, 255));
        if (n < span) begin
          w.action = ACT_LOAD;
          w.sel = SEL_BITS'(n);
        end else begin
          w.action = ($urandom_range(0, 99) < 45) ? ACT_LOAD : ACT_ALLOC;
          if (span != 0 && $urandom_range(0, 9) != 0)
            w.sel = SEL_BITS'($urandom_range(0, span - 1));
          else
            w.sel = SEL_BITS'($urandom_range(0, 15));
        end
        send_word(w, 1'b0, '0);
      end
      quiet = 1'b0;
    end

    in_valid_i <= 1'b0;
    while (predicted_outcomes.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
